[hdl/ink_pkg.sv]
// Package for the ink segment store: widths, command codes, bounds type.
// No dependencies.
package ink_pkg;

  localparam int unsigned MaxSegmentsDef = 1024;
  localparam int unsigned CoordFracBitsDef = 4;
  localparam logic [15:0] PenWidthReset = 16'd48;
  localparam int signed RectMin = -16384;
  localparam int signed RectMax = 16383;

  typedef enum logic [1:0] {
    CmdMove  = 2'd0,
    CmdLine  = 2'd1,
    CmdClear = 2'd2,
    CmdErase = 2'd3
  } cmd_e;

  localparam logic CfgPenWidth = 1'b0;
  localparam logic CfgAntialias = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StErRead,
    StErWait,
    StErMul,
    StErCmp,
    StErWide0,
    StErWide1,
    StErWide2,
    StErWide3,
    StErDec,
    StRect,
    StOut
  } state_e;

  // bounds in half fraction units, 20 bits signed is enough
  typedef struct packed {
    logic signed [19:0] l;
    logic signed [19:0] t;
    logic signed [19:0] r;
    logic signed [19:0] b;
  } bnd_t;

endpackage

[hdl/ink_segment_store_with_eraser.sv]
// Ink segment store with eraser: top level. Uses ink_pkg and ink_ram.
// Move/line/clear go from idle to StOut, which loads the output register;
// the input stall drops when the block is back in idle.
// Erase: for each stored segment read, wait, differences, products, three
// partial product steps and the long compare, write back; then StRect, StOut.
// One item in work at a time; a stalled result keeps a later item in StOut,
// so holding the input off. Reset: asynchronous active low; store empty, no
// last point, pen_width 48, antialias 1; memories not cleared.
module ink_segment_store_with_eraser #(
  parameter int unsigned MaxSegments = ink_pkg::MaxSegmentsDef,
  parameter int unsigned CoordFracBits = ink_pkg::CoordFracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] x_i,
  input  logic [15:0] y_i,
  input  logic [15:0] stroke_width_i,
  input  logic        use_pen_width_i,
  input  logic [15:0] radius_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        dirty_valid_o,
  output logic        full_refresh_o,
  output logic signed [14:0] rect_left_o,
  output logic signed [14:0] rect_top_o,
  output logic signed [14:0] rect_right_o,
  output logic signed [14:0] rect_bottom_o,
  output logic [10:0] segments_held_o,
  output logic        store_full_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned AW = $clog2(MaxSegments);
  localparam int unsigned CW = AW + 1;
  localparam int signed HalfUnit = 2 ** (CoordFracBits + 1);

  // ---- registers
  ink_pkg::state_e st_q, st_d;
  logic [15:0] pen_q;
  logic        aa_q;
  logic [CW-1:0] cnt_q;
  logic [15:0] lx_q, ly_q;
  logic        have_q;

  logic [15:0] px_q, py_q, rad_q;
  logic [CW-1:0] rd_q, kept_q;
  logic        val_q, full_q, drop_q;
  ink_pkg::bnd_t acc_q;

  // segment memories: ends packed {by,bx,ay,ax}, widths
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wends, rends;
  logic [15:0] wwid, rwid;

  ink_ram #(.Width(64), .Depth(MaxSegments)) u_ends (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wends), .raddr_i(raddr), .rdata_o(rends)
  );
  ink_ram #(.Width(16), .Depth(MaxSegments)) u_wid (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wwid), .raddr_i(raddr), .rdata_o(rwid)
  );
  assign raddr = rd_q[AW-1:0];

  // captured segment under test
  logic [63:0] e_q;
  logic [15:0] w_q;
  // distance datapath registers
  logic signed [17:0] dx_q, dy_q, abx_q, aby_q, bdx_q, bdy_q;
  logic [33:0] len2_q, sqa_q, sqb_q;
  logic signed [35:0] dot_q;
  logic [34:0] cr_q;      // |cross|
  logic [31:0] r2_q;
  logic [69:0] lhs_q, rhs_q; // cr*cr and r2*len2
  logic        hit_q;

  // ---- segment bounds (margin etc.)
  function automatic ink_pkg::bnd_t seg_bnd(input logic [63:0] e, input logic [15:0] w,
                                            input logic aa);
    logic signed [19:0] ax, ay, bx, by, m;
    ink_pkg::bnd_t o;
    ax = 20'(e[15:0]); ay = 20'(e[31:16]);
    bx = 20'(e[47:32]); by = 20'(e[63:48]);
    m = 20'(w) + (aa ? 20'(2 * HalfUnit) : 20'(HalfUnit));
    o.l = 20'(2 * ((ax < bx) ? ax : bx)) - m;
    o.t = 20'(2 * ((ay < by) ? ay : by)) - m;
    o.r = 20'(2 * ((ax > bx) ? ax : bx)) + m;
    o.b = 20'(2 * ((ay > by) ? ay : by)) + m;
    return o;
  endfunction

  function automatic ink_pkg::bnd_t bunion(input ink_pkg::bnd_t a, input ink_pkg::bnd_t c);
    ink_pkg::bnd_t o;
    o.l = (a.l < c.l) ? a.l : c.l;
    o.t = (a.t < c.t) ? a.t : c.t;
    o.r = (a.r > c.r) ? a.r : c.r;
    o.b = (a.b > c.b) ? a.b : c.b;
    return o;
  endfunction

  // floor / ceil by HalfUnit (power of two) then saturate
  function automatic logic signed [14:0] sat(input logic signed [19:0] v);
    logic signed [19:0] q;
    q = v >>> (CoordFracBits + 1);
    if (q < 20'(ink_pkg::RectMin)) return 15'(ink_pkg::RectMin);
    if (q > 20'(ink_pkg::RectMax)) return 15'(ink_pkg::RectMax);
    return q[14:0];
  endfunction

  // ---- control
  logic in_acc, out_acc, run;
  assign in_stall_o  = (st_q != ink_pkg::StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign cfg_ready_o = (st_q == ink_pkg::StIdle);
  assign run = (rd_q < cnt_q);

  always_comb begin
    st_d = st_q;
    case (st_q)
      ink_pkg::StIdle:    if (in_acc) begin
        st_d = (ink_pkg::cmd_e'(command_i) == ink_pkg::CmdErase) ? ink_pkg::StErRead
                                                                  : ink_pkg::StOut;
      end
      ink_pkg::StErRead:  st_d = run ? ink_pkg::StErWait : ink_pkg::StRect;
      ink_pkg::StErWait:  st_d = ink_pkg::StErMul;
      ink_pkg::StErMul:   st_d = ink_pkg::StErCmp;
      ink_pkg::StErCmp:   st_d = ink_pkg::StErWide0;
      ink_pkg::StErWide0: st_d = ink_pkg::StErWide1;
      ink_pkg::StErWide1: st_d = ink_pkg::StErWide2;
      ink_pkg::StErWide2: st_d = ink_pkg::StErWide3;
      ink_pkg::StErWide3: st_d = ink_pkg::StErDec;
      ink_pkg::StErDec:   st_d = ink_pkg::StErRead;
      ink_pkg::StRect:    st_d = ink_pkg::StOut;
      ink_pkg::StOut:     if (!out_valid_o || out_stall_i == 1'b0) st_d = ink_pkg::StIdle;
      default:            st_d = ink_pkg::StIdle;
    endcase
  end

  // memory write: line append or erase compaction
  logic line_wr;
  assign line_wr = in_acc && ink_pkg::cmd_e'(command_i) == ink_pkg::CmdLine && have_q
                   && (cnt_q < CW'(MaxSegments));
  always_comb begin
    we = 1'b0; waddr = cnt_q[AW-1:0];
    wends = {y_i, x_i, ly_q, lx_q}; wwid = use_pen_width_i ? pen_q : stroke_width_i;
    if (line_wr) begin
      we = 1'b1;
    end else if (st_q == ink_pkg::StErDec && !hit_q) begin
      we = 1'b1; waddr = kept_q[AW-1:0]; wends = e_q; wwid = w_q;
    end
  end

  // ---- datapath
  ink_pkg::bnd_t sb, er;
  assign sb = seg_bnd(e_q, w_q, aa_q);
  always_comb begin
    er.l = 20'(2 * ($signed({4'd0, px_q}) - $signed({4'd0, rad_q})));
    er.t = 20'(2 * ($signed({4'd0, py_q}) - $signed({4'd0, rad_q})));
    er.r = 20'(2 * ({4'd0, px_q} + {4'd0, rad_q}));
    er.b = 20'(2 * ({4'd0, py_q} + {4'd0, rad_q}));
  end

  logic [34:0] cra;
  logic signed [36:0] crs;
  assign crs = 37'(dx_q * aby_q) - 37'(dy_q * abx_q);
  assign cra = crs[36] ? 35'(-crs) : 35'(crs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ink_pkg::StIdle;
      pen_q <= ink_pkg::PenWidthReset;
      aa_q <= 1'b1;
      cnt_q <= '0;
      lx_q <= '0; ly_q <= '0;
      have_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == ink_pkg::CfgPenWidth) pen_q <= cfg_data_i;
        else if (cfg_index_i == ink_pkg::CfgAntialias) aa_q <= cfg_data_i[0];
      end
      if (out_acc) out_valid_o <= 1'b0;
      if (st_q == ink_pkg::StOut && !(out_valid_o && out_stall_i)) out_valid_o <= 1'b1;
      if (in_acc) begin
        case (ink_pkg::cmd_e'(command_i))
          ink_pkg::CmdMove: begin
            lx_q <= x_i; ly_q <= y_i; have_q <= 1'b1;
          end
          ink_pkg::CmdLine: begin
            lx_q <= x_i; ly_q <= y_i; have_q <= 1'b1;
            if (line_wr) cnt_q <= cnt_q + 1'b1;
          end
          ink_pkg::CmdClear: begin
            cnt_q <= '0; have_q <= 1'b0;
          end
          default: have_q <= 1'b0;
        endcase
      end
      if (st_q == ink_pkg::StRect && val_q) cnt_q <= kept_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= x_i; py_q <= y_i; rad_q <= radius_i;
      rd_q <= '0; kept_q <= '0;
      val_q <= line_wr; full_q <= (ink_pkg::cmd_e'(command_i) == ink_pkg::CmdClear);
      drop_q <= ink_pkg::cmd_e'(command_i) == ink_pkg::CmdLine && have_q && !line_wr;
      r2_q <= radius_i * radius_i;
      e_q <= {y_i, x_i, ly_q, lx_q};
      w_q <= use_pen_width_i ? pen_q : stroke_width_i;
    end
    case (st_q)
      ink_pkg::StErRead: rd_q <= rd_q;
      ink_pkg::StErWait: begin
        e_q <= rends; w_q <= rwid;
      end
      ink_pkg::StErMul: begin
        dx_q  <= $signed({2'b0, px_q}) - $signed({2'b0, e_q[15:0]});
        dy_q  <= $signed({2'b0, py_q}) - $signed({2'b0, e_q[31:16]});
        abx_q <= $signed({2'b0, e_q[47:32]}) - $signed({2'b0, e_q[15:0]});
        aby_q <= $signed({2'b0, e_q[63:48]}) - $signed({2'b0, e_q[31:16]});
        bdx_q <= $signed({2'b0, px_q}) - $signed({2'b0, e_q[47:32]});
        bdy_q <= $signed({2'b0, py_q}) - $signed({2'b0, e_q[63:48]});
      end
      ink_pkg::StErCmp: begin
        len2_q <= 34'(abx_q * abx_q) + 34'(aby_q * aby_q);
        dot_q  <= 36'(dx_q * abx_q) + 36'(dy_q * aby_q);
        sqa_q  <= 34'(dx_q * dx_q) + 34'(dy_q * dy_q);
        sqb_q  <= 34'(bdx_q * bdx_q) + 34'(bdy_q * bdy_q);
        cr_q   <= cra;
      end
      ink_pkg::StErWide0: begin
        lhs_q <= 70'(cr_q[16:0] * cr_q[16:0]);
        rhs_q <= 70'(len2_q[16:0] * r2_q);
      end
      ink_pkg::StErWide1: begin
        lhs_q <= lhs_q + (70'(cr_q[34:17] * cr_q[16:0]) << 18);
        rhs_q <= rhs_q + (70'(len2_q[33:17] * r2_q) << 17);
      end
      ink_pkg::StErWide2: begin
        lhs_q <= lhs_q + (70'(cr_q[34:17] * cr_q[34:17]) << 34);
      end
      ink_pkg::StErWide3: begin
        if (len2_q == '0 || dot_q <= 0) hit_q <= {2'b0, sqa_q} < {2'b0, r2_q};
        else if (dot_q >= $signed({2'b0, len2_q})) hit_q <= {2'b0, sqb_q} < {2'b0, r2_q};
        else hit_q <= lhs_q < rhs_q;
      end
      ink_pkg::StErDec: begin
        rd_q <= rd_q + 1'b1;
        if (hit_q) begin
          val_q <= 1'b1;
          acc_q <= val_q ? bunion(acc_q, sb) : sb;
        end else begin
          kept_q <= kept_q + 1'b1;
        end
      end
      ink_pkg::StRect: if (val_q) begin
        acc_q.l <= ((acc_q.l < er.l) ? acc_q.l : er.l) - 20'(HalfUnit);
        acc_q.t <= ((acc_q.t < er.t) ? acc_q.t : er.t) - 20'(HalfUnit);
        acc_q.r <= ((acc_q.r > er.r) ? acc_q.r : er.r) + 20'(HalfUnit);
        acc_q.b <= ((acc_q.b > er.b) ? acc_q.b : er.b) + 20'(HalfUnit);
      end
      default: ;
    endcase
    if (st_q == ink_pkg::StIdle && in_acc && line_wr) begin
      acc_q <= seg_bnd({y_i, x_i, ly_q, lx_q}, use_pen_width_i ? pen_q : stroke_width_i, aa_q);
    end
    if (st_q == ink_pkg::StOut && !(out_valid_o && out_stall_i)) begin
      dirty_valid_o <= val_q;
      full_refresh_o <= full_q;
      store_full_o <= drop_q;
      segments_held_o <= 11'(cnt_q);
      rect_left_o   <= val_q ? sat(acc_q.l) : '0;
      rect_top_o    <= val_q ? sat(acc_q.t) : '0;
      rect_right_o  <= val_q ? -sat(-acc_q.r) : '0;
      rect_bottom_o <= val_q ? -sat(-acc_q.b) : '0;
    end
  end

endmodule

[hdl/ink_ram.sv]
// Generic simple dual port RAM (one write port, one read port) with registered read.
// No dependencies.
module ink_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
